[sv/epsw_pkg.sv]
// ----------------------------------------------------------------------------
// epsw_pkg
// Shared constants, register indexes and the job record passed from the
// classifier to the byte sequencer.
// ----------------------------------------------------------------------------
package epsw_pkg;

  // Sizes of the datapath
  localparam int unsigned MaxElementBytes = 8;
  localparam int unsigned PatternEntries  = 6;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned SizeFieldW      = 4;
  localparam int unsigned CountFieldW     = 16;
  localparam int unsigned PatternW        = SizeFieldW + CountFieldW;

  // Configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = PatternW;

  // Derived widths
  localparam int unsigned EntryW = $clog2(PatternEntries + 1);
  localparam int unsigned IdxW   = $clog2(MaxElementBytes);
  localparam int unsigned CntW   = $clog2(MaxElementBytes + 1);

  // Job queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Register indexes on the configuration port
  typedef enum logic [CfgAddrW-1:0] {
    CfgSwapEnable,
    CfgPattern0,
    CfgPattern1,
    CfgPattern2,
    CfgPattern3,
    CfgPattern4,
    CfgPattern5
  } cfg_addr_e;

  // One input's worth of output bytes: emit count bytes from bytes[],
  // starting at index first, walking down when down is set.
  typedef struct packed {
    logic [MaxElementBytes-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]                       first;
    logic [CntW-1:0]                       count;
    logic                                  down;
  } job_t;

endpackage

[sv/epsw_front.sv]
// ----------------------------------------------------------------------------
// epsw_front
// Takes input bytes, tracks the pattern position and the element being
// collected, and turns each byte into a job of zero to eight output bytes.
// ----------------------------------------------------------------------------
module epsw_front import epsw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic                record_start_i,
  input  logic                q_full_i,
  output logic                push_o,
  output job_t                job_o
);

  // Configuration registers
  logic                swap_en_q;
  logic [PatternW-1:0] pat_q [PatternEntries];

  // Pattern position and element buffer
  logic [EntryW-1:0]      entry_q, entry_d;
  logic [CountFieldW-1:0] units_q, units_d;
  logic                   done_q, done_d;
  logic [IdxW-1:0]        bc_q, bc_d;
  logic [ByteW-1:0]       buf_q [MaxElementBytes];

  logic                   accept;
  logic                   collect;
  logic [EntryW-1:0]      e0, e;
  logic [CountFieldW-1:0] u0, u;
  logic                   d0, d;
  logic                   stop;
  logic [IdxW-1:0]        bce;
  logic [SizeFieldW-1:0]  sz;
  logic [CntW-1:0]        sz_sat;
  logic [CntW-1:0]        held;
  logic                   emit_el;
  logic                   tail;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (job_o.count != '0);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_en_q <= 1'b1;
      for (int i = 0; i < PatternEntries; i++) begin
        pat_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CfgSwapEnable) begin
        swap_en_q <= cfg_wdata_i[0];
      end
      for (int i = 0; i < PatternEntries; i++) begin
        if (cfg_addr_i == CfgAddrW'(int'(CfgPattern0) + i)) begin
          pat_q[i] <= cfg_wdata_i[PatternW-1:0];
        end
      end
    end
  end

  // Restart, entry resolution and job building
  always_comb begin
    e0 = record_start_i ? '0 : entry_q;
    u0 = record_start_i ? pat_q[0][PatternW-1:SizeFieldW] : units_q;
    d0 = record_start_i ? 1'b0 : done_q;
    bce = record_start_i ? '0 : bc_q;

    // skip entries with no elements left, stop at end marker or table end
    e    = e0;
    u    = u0;
    d    = d0;
    stop = d0;
    for (int g = 0; g <= PatternEntries; g++) begin
      if (!stop) begin
        if (int'(e) >= PatternEntries) begin
          d    = 1'b1;
          stop = 1'b1;
        end else if (pat_q[e][SizeFieldW-1:0] == '0) begin
          d    = 1'b1;
          stop = 1'b1;
        end else if (u != '0) begin
          stop = 1'b1;
        end else begin
          e = e + 1'b1;
          if (int'(e) < PatternEntries) begin
            u = pat_q[e][PatternW-1:SizeFieldW];
          end else begin
            u = '0;
          end
        end
      end
    end
    if (!d && (u == '0)) begin
      d = 1'b1;
    end

    // element size of the resolved entry, saturated
    if (int'(e) < PatternEntries) begin
      sz = pat_q[e][SizeFieldW-1:0];
    end else begin
      sz = '0;
    end
    if (int'(sz) > MaxElementBytes) begin
      sz_sat = CntW'(MaxElementBytes);
    end else begin
      sz_sat = CntW'(sz);
    end
    held    = CntW'(bce) + 1'b1;
    emit_el = swap_en_q && !d && (held >= sz_sat);
    collect = swap_en_q && !d && !emit_el;
    tail    = !swap_en_q || d || emit_el;

    // held bytes with the new byte placed after them
    for (int i = 0; i < MaxElementBytes; i++) begin
      job_o.bytes[i] = (IdxW'(i) == bc_q) ? data_byte_i : buf_q[i];
    end
    job_o.first = '0;
    job_o.count = '0;
    job_o.down  = 1'b0;
    if (record_start_i) begin
      // flush in arrival order, then the byte if it leaves at once
      job_o.count = CntW'(bc_q) + CntW'(tail);
    end else if (!swap_en_q) begin
      job_o.first = bc_q;
      job_o.count = CntW'(1);
    end else if (d) begin
      job_o.count = CntW'(bc_q) + 1'b1;
    end else if (emit_el) begin
      job_o.first = bc_q;
      job_o.count = CntW'(bc_q) + 1'b1;
      job_o.down  = 1'b1;
    end

    // next pattern state
    if (swap_en_q) begin
      entry_d = e;
      units_d = emit_el ? (u - 1'b1) : u;
      done_d  = d;
    end else begin
      entry_d = e0;
      units_d = u0;
      done_d  = d0;
    end
    if (collect) begin
      bc_d = bce + 1'b1;
    end else if (!swap_en_q && !record_start_i) begin
      bc_d = bc_q;
    end else begin
      bc_d = '0;
    end
  end

  // Pattern state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      units_q <= '0;
      done_q  <= 1'b0;
      bc_q    <= '0;
    end else if (accept) begin
      entry_q <= entry_d;
      units_q <= units_d;
      done_q  <= done_d;
      bc_q    <= bc_d;
    end
  end

  // Element buffer, written while collecting
  always_ff @(posedge clk_i) begin
    if (accept && collect) begin
      buf_q[bce] <= data_byte_i;
    end
  end

endmodule

[sv/epsw_queue.sv]
// ----------------------------------------------------------------------------
// epsw_queue
// Small job queue that decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
module epsw_queue import epsw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t head_o
);

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (int'(wr_q) == QueueDepth - 1) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (int'(rd_q) == QueueDepth - 1) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

[sv/epsw_back.sv]
// ----------------------------------------------------------------------------
// epsw_back
// Walks the head job one byte per cycle into the output register while
// the output is not stalled, and marks the final byte of each job.
// ----------------------------------------------------------------------------
module epsw_back import epsw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  job_t             q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_last_o
);

  logic [IdxW-1:0]  k_q;
  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;

  logic             load;
  logic             last;
  logic [IdxW-1:0]  idx;

  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign last    = ((CntW'(k_q) + 1'b1) == q_head_i.count);
  assign idx     = q_head_i.down ? (q_head_i.first - k_q) : (q_head_i.first + k_q);
  assign q_pop_o = load && last;

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  // Byte counter within the job and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      valid_q <= 1'b0;
    end else if (load) begin
      k_q     <= last ? '0 : k_q + 1'b1;
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= q_head_i.bytes[idx];
      last_q <= last;
    end
  end

endmodule

[sv/pattern_driven_endian_swapper_top.sv]
// Path: a byte that leaves at once passes the job queue and then the output register.
// Throughput: one input byte per cycle while the four-job queue has room; the
//   output register drains one byte per cycle while m_axis_tready is high, so an
//   input that releases a run of bytes holds the output side until the run has left.
// Reset: swap enabled, all pattern entries zero, pattern at its first entry,
//   no element held, queue and output empty.
// ----------------------------------------------------------------------------
// pattern_driven_endian_swapper_top
// Record byte-order swapper: classifier front, job queue, byte sequencer back.
// ----------------------------------------------------------------------------
module pattern_driven_endian_swapper_top import epsw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  logic                s_axis_tuser_i,   // [0] record_start
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [ByteW-1:0]    m_axis_tdata_o,   // [7:0] out_byte
  output logic                m_axis_tlast_o    // last_of_run
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t q_head;

  // Classify input bytes into jobs
  epsw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .data_byte_i    (s_axis_tdata_i),
    .record_start_i (s_axis_tuser_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .job_o          (push_job)
  );

  // Job queue
  epsw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .head_o     (q_head)
  );

  // Serialize jobs to the output stream
  epsw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
